### hdl/v4cpa_pkg.sv
// Shared types and constants for the vec4 constant pool allocator.
// Used by every module of the block; no dependencies.
`default_nettype none
package v4cpa_pkg;

	localparam int unsigned COMP_N   = 4;
	localparam int unsigned SLOTS_DEF = 256;
	localparam int unsigned TAG_W    = 4;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned CFG_W    = 10;
	localparam int unsigned ROW_W    = 9;
	localparam int unsigned CNT_IN_W = 3;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [WORD_W-1:0] word;
	} slot_t;

	typedef struct packed {
		logic clear;
		logic step;
	} scan_ctl_t;

endpackage
`default_nettype wire

### hdl/v4cpa_table.sv
// Slot table memory: one write port, one registered read port.
// Depends on v4cpa_pkg for the slot entry type.
`default_nettype none
module v4cpa_table #(
	parameter int unsigned SLOTS = v4cpa_pkg::SLOTS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
	input  wire v4cpa_pkg::slot_t         wr_data,
	input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
	output v4cpa_pkg::slot_t              rd_data
);
	import v4cpa_pkg::*;

	slot_t mem [SLOTS];
	slot_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

### hdl/v4cpa_lane.sv
// One compare lane: matches a table slot against one request component.
// Depends on v4cpa_pkg for the slot entry type.
`default_nettype none
module v4cpa_lane (
	input  wire v4cpa_pkg::slot_t                    entry,
	input  wire logic [v4cpa_pkg::TAG_W-1:0]         req_tag,
	input  wire logic [v4cpa_pkg::WORD_W-1:0]        req_word,
	output logic                                     match
);
	import v4cpa_pkg::*;

	assign match = (entry.tag == '0) || ((entry.tag == req_tag) && (entry.word == req_word));

endmodule
`default_nettype wire

### hdl/v4cpa_merge.sv
// Merge stage: chains lane matches into live windows and flags the first full one.
// Depends on v4cpa_pkg for the scan control struct.
`default_nettype none
module v4cpa_merge #(
	parameter int unsigned SLOTS = v4cpa_pkg::SLOTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire v4cpa_pkg::scan_ctl_t         ctl,
	input  wire logic [v4cpa_pkg::COMP_N-1:0] match,
	input  wire logic [1:0]                   comp_last,
	input  wire logic [$clog2(SLOTS+1)-1:0]   slot,
	output logic                              hit,
	output logic [$clog2(SLOTS+1)-1:0]        start
);
	import v4cpa_pkg::*;

	localparam int unsigned CNT_W = $clog2(SLOTS+1);

	logic [COMP_N-1:1] alive_q;
	logic [COMP_N-1:0] alive;

	assign alive[0] = match[0];
	assign alive[1] = alive_q[1] & match[1];
	assign alive[2] = alive_q[2] & match[2];
	assign alive[3] = alive_q[3] & match[3];

	assign hit   = ctl.step & alive[comp_last];
	assign start = slot - CNT_W'(comp_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '0;
		end else if (ctl.clear) begin
			alive_q <= '0;
		end else if (ctl.step) begin
			alive_q <= alive[COMP_N-2:0];
		end
	end

endmodule
`default_nettype wire

### hdl/vec4_constant_pool_alloc_core.sv
// Each item scans the filled slots, then writes n (hit) or pad + n (miss) slots,
// then loads the output register.
// Throughput: one item at a time; the scan reads one slot per cycle from the table port.
// Overflow skips the write phase. A waiting result does not block the next transfer in.
// Reset clears the fill count, base offset and control; the table is not cleared.
`default_nettype none
module vec4_constant_pool_alloc_core #(
	parameter int unsigned SLOTS = v4cpa_pkg::SLOTS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [v4cpa_pkg::CFG_W-1:0]       cfg_wr_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [v4cpa_pkg::CNT_IN_W-1:0]    comp_count,
	input  wire logic [v4cpa_pkg::TAG_W-1:0]       tag_a,
	input  wire logic [v4cpa_pkg::WORD_W-1:0]      word_a,
	input  wire logic [v4cpa_pkg::TAG_W-1:0]       tag_b,
	input  wire logic [v4cpa_pkg::WORD_W-1:0]      word_b,
	input  wire logic [v4cpa_pkg::TAG_W-1:0]       tag_c,
	input  wire logic [v4cpa_pkg::WORD_W-1:0]      word_c,
	input  wire logic [v4cpa_pkg::TAG_W-1:0]       tag_d,
	input  wire logic [v4cpa_pkg::WORD_W-1:0]      word_d,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [v4cpa_pkg::ROW_W-1:0]            row_index,
	output logic [1:0]                             lane_select,
	output logic                                   whole_vector,
	output logic                                   was_reused,
	output logic                                   overflow
);
	import v4cpa_pkg::*;

	localparam int unsigned IDX_W = $clog2(SLOTS);
	localparam int unsigned CNT_W = $clog2(SLOTS+1);
	localparam int unsigned TOT_W = CNT_W + 1;
	localparam int unsigned SUM_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
	localparam logic [TOT_W-1:0] SLOTS_L = TOT_W'(SLOTS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]  filled_q;
	logic [CFG_W-1:0]  base_q;
	logic [1:0]        comp_last_q;
	logic [TAG_W-1:0]  tg_q [COMP_N];
	logic [WORD_W-1:0] wd_q [COMP_N];
	logic [CNT_W-1:0]  issue_q;
	logic              rd_vld_s1;
	logic [CNT_W-1:0]  slot_s1;
	logic [IDX_W-1:0]  wr_ptr_q;
	logic [2:0]        wr_i_q;
	logic [2:0]        wr_pad_q;
	logic [2:0]        wr_len_q;
	logic [CNT_W-1:0]  res_slot_q;
	logic              res_hit_q;
	logic              res_ovf_q;
	logic              out_valid_q;
	logic [ROW_W-1:0]  row_q;
	logic [1:0]        lane_q;
	logic              whole_q;
	logic              reused_q;
	logic              ovf_q;

	logic              in_xfer;
	logic [1:0]        cc_last;
	logic              issue_now;
	scan_ctl_t         ctl;
	slot_t             rd_data;
	slot_t             wr_data;
	logic [COMP_N-1:0] match;
	logic              hit;
	logic [CNT_W-1:0]  hit_start;
	logic [2:0]        n_eff;
	logic [1:0]        fill_rem;
	logic [2:0]        pad;
	logic [TOT_W-1:0]  total;
	logic              miss_done;
	logic [1:0]        wr_comp;
	logic              wr_is_pad;
	logic [SUM_W-1:0]  sum;
	logic              res_load;
	logic [TAG_W-1:0]  req_tag [COMP_N];
	logic [WORD_W-1:0] req_word [COMP_N];

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid & ~in_stall;

	always_comb begin
		priority if (comp_count == '0) begin
			cc_last = 2'd0;
		end else if (comp_count >= CNT_IN_W'(COMP_N)) begin
			cc_last = 2'd3;
		end else begin
			cc_last = 2'(comp_count - CNT_IN_W'(1));
		end
	end

	assign req_tag[0]  = tag_a;
	assign req_tag[1]  = tag_b;
	assign req_tag[2]  = tag_c;
	assign req_tag[3]  = tag_d;
	assign req_word[0] = word_a;
	assign req_word[1] = word_b;
	assign req_word[2] = word_c;
	assign req_word[3] = word_d;

	assign issue_now  = (state_q == ST_SCAN) && (issue_q < filled_q) && !hit;
	assign ctl.clear  = in_xfer;
	assign ctl.step   = (state_q == ST_SCAN) && rd_vld_s1;

	v4cpa_table #(.SLOTS(SLOTS)) u_table (
		.clk     (clk),
		.wr_en   (state_q == ST_WRITE),
		.wr_addr (wr_ptr_q),
		.wr_data (wr_data),
		.rd_addr (issue_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	for (genvar g = 0; g < COMP_N; g++) begin : g_lane
		v4cpa_lane u_lane (
			.entry    (rd_data),
			.req_tag  (tg_q[g]),
			.req_word (wd_q[g]),
			.match    (match[g])
		);
	end

	v4cpa_merge #(.SLOTS(SLOTS)) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.match     (match),
		.comp_last (comp_last_q),
		.slot      (slot_s1),
		.hit       (hit),
		.start     (hit_start)
	);

	assign n_eff     = 3'(comp_last_q) + 3'd1;
	assign fill_rem  = filled_q[1:0];
	assign pad       = ((fill_rem != 2'd0) && (n_eff > 3'(fill_rem))) ? n_eff - 3'(fill_rem)
	                                                                  : 3'd0;
	assign total     = TOT_W'(filled_q) + TOT_W'(pad) + TOT_W'(n_eff);
	assign miss_done = (state_q == ST_SCAN) && !hit && !rd_vld_s1 && (issue_q == filled_q);

	assign wr_is_pad    = (wr_i_q < wr_pad_q);
	assign wr_comp      = 2'(wr_i_q - wr_pad_q);
	assign wr_data.tag  = wr_is_pad ? '0 : tg_q[wr_comp];
	assign wr_data.word = wr_is_pad ? '0 : wd_q[wr_comp];

	assign sum = SUM_W'(res_slot_q) + SUM_W'(base_q);

	assign res_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			for (int k = 0; k < COMP_N; k++) begin
				tg_q[k] <= req_tag[k];
				wd_q[k] <= req_word[k];
			end
		end
		slot_s1 <= issue_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			filled_q    <= '0;
			base_q      <= '0;
			comp_last_q <= '0;
			issue_q     <= '0;
			rd_vld_s1   <= 1'b0;
			wr_ptr_q    <= '0;
			wr_i_q      <= '0;
			wr_pad_q    <= '0;
			wr_len_q    <= '0;
			res_slot_q  <= '0;
			res_hit_q   <= 1'b0;
			res_ovf_q   <= 1'b0;
			out_valid_q <= 1'b0;
			row_q       <= '0;
			lane_q      <= '0;
			whole_q     <= 1'b0;
			reused_q    <= 1'b0;
			ovf_q       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			rd_vld_s1 <= issue_now;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						comp_last_q <= cc_last;
						issue_q     <= '0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue_now) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (hit) begin
						wr_ptr_q   <= hit_start[IDX_W-1:0];
						wr_i_q     <= '0;
						wr_pad_q   <= '0;
						wr_len_q   <= n_eff;
						res_slot_q <= hit_start;
						res_hit_q  <= 1'b1;
						res_ovf_q  <= 1'b0;
						state_q    <= ST_WRITE;
					end else if (miss_done) begin
						res_hit_q <= 1'b0;
						if (total > SLOTS_L) begin
							res_ovf_q <= 1'b1;
							state_q   <= ST_FINISH;
						end else begin
							wr_ptr_q   <= filled_q[IDX_W-1:0];
							wr_i_q     <= '0;
							wr_pad_q   <= pad;
							wr_len_q   <= pad + n_eff;
							res_slot_q <= filled_q + CNT_W'(pad);
							res_ovf_q  <= 1'b0;
							filled_q   <= total[CNT_W-1:0];
							state_q    <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					wr_ptr_q <= wr_ptr_q + IDX_W'(1);
					wr_i_q   <= wr_i_q + 3'd1;
					if (wr_i_q == wr_len_q - 3'd1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (res_load) begin
						ovf_q       <= res_ovf_q;
						if (res_ovf_q) begin
							row_q    <= '0;
							lane_q   <= '0;
							whole_q  <= 1'b0;
							reused_q <= 1'b0;
						end else begin
							row_q    <= sum[ROW_W+1:2];
							lane_q   <= sum[1:0];
							whole_q  <= (comp_last_q == 2'd3);
							reused_q <= res_hit_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign row_index    = row_q;
	assign lane_select  = lane_q;
	assign whole_vector = whole_q;
	assign was_reused   = reused_q;
	assign overflow     = ovf_q;

endmodule
`default_nettype wire

### hdl/v4cpa_checker.sv
// Port-level checks for the constant pool allocator, and the bind that attaches them.
// Depends on v4cpa_pkg and vec4_constant_pool_alloc_core.
`default_nettype none
module v4cpa_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic                              in_stall,
	input  wire logic                              out_valid,
	input  wire logic                              out_stall,
	input  wire logic [v4cpa_pkg::ROW_W-1:0]       row_index,
	input  wire logic [1:0]                        lane_select,
	input  wire logic                              whole_vector,
	input  wire logic                              was_reused,
	input  wire logic                              overflow
);
	import v4cpa_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> !was_reused && !whole_vector &&
			row_index == '0 && lane_select == '0)
		else $error("overflow result carries non-zero fields");

	a_ovf_reuse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(overflow && was_reused))
		else $error("overflow and reuse flagged together");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transfer taken while a request is in work");

endmodule

bind vec4_constant_pool_alloc_core v4cpa_checker u_v4cpa_checker (.*);
`default_nettype wire

### sim/tb.sv
// Testbench for vec4_constant_pool_alloc_core: drives constant requests with random gaps,
// predicts all result fields from its own copy of the slot table, checks every transfer.
// Depends on v4cpa_pkg and the core module only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import v4cpa_pkg::*;

	localparam int unsigned CAP   = SLOTS_DEF;
	localparam int unsigned LIMIT = 1_000_000;

	typedef struct {
		logic [CNT_IN_W-1:0] count;
		logic [TAG_W-1:0]    tag [COMP_N];
		logic [WORD_W-1:0]   word [COMP_N];
	} const_req_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [1:0]       lane;
		logic             whole;
		logic             reused;
		logic             ovf;
	} alloc_res_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CFG_W-1:0]    cfg_wr_data;
	logic                in_valid;
	logic                in_stall;
	logic [CNT_IN_W-1:0] comp_count;
	logic [TAG_W-1:0]    tag_a, tag_b, tag_c, tag_d;
	logic [WORD_W-1:0]   word_a, word_b, word_c, word_d;
	logic                out_valid;
	logic                out_stall;
	logic [ROW_W-1:0]    row_index;
	logic [1:0]          lane_select;
	logic                whole_vector;
	logic                was_reused;
	logic                overflow;

	vec4_constant_pool_alloc_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.comp_count  (comp_count),
		.tag_a       (tag_a),
		.word_a      (word_a),
		.tag_b       (tag_b),
		.word_b      (word_b),
		.tag_c       (tag_c),
		.word_c      (word_c),
		.tag_d       (tag_d),
		.word_d      (word_d),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.row_index   (row_index),
		.lane_select (lane_select),
		.whole_vector(whole_vector),
		.was_reused  (was_reused),
		.overflow    (overflow)
	);

	logic [TAG_W-1:0]  pool_tag [CAP];
	logic [WORD_W-1:0] pool_word [CAP];
	int unsigned       pool_fill;
	logic [CFG_W-1:0]  lane_base;
	logic [TAG_W-1:0]  pair_tag [16];
	logic [WORD_W-1:0] pair_word [16];

	const_req_t  pending [$];
	alloc_res_t  allocs_due [$];
	const_req_t  cur_req;
	alloc_res_t  head;
	int unsigned queued_n, sent_n, mismatches, cycle_n;
	int unsigned gap_left, stall_left;
	bit          calm, req_taken, res_taken;

	function automatic alloc_res_t allocate(const_req_t q);
		alloc_res_t  res;
		int unsigned n, p, k, slot, pad;
		logic [11:0] addr;
		bit          hit, ok;
		n = q.count;
		if (n == 0)
			n = 1;
		if (n > COMP_N)
			n = COMP_N;
		hit = 0;
		slot = 0;
		res = '0;
		for (p = 0; p < pool_fill && !hit; p++) begin
			ok = (p + n <= pool_fill);
			for (k = 0; k < n && ok; k++)
				if (pool_tag[p + k] != 0 &&
				    (pool_tag[p + k] != q.tag[k] || pool_word[p + k] != q.word[k]))
					ok = 0;
			if (ok) begin
				hit = 1;
				slot = p;
			end
		end
		if (!hit) begin
			pad = (pool_fill % 4 != 0 && n > pool_fill % 4) ? n - pool_fill % 4 : 0;
			if (pool_fill + pad + n > CAP) begin
				res.ovf = 1'b1;
				return res;
			end
			for (k = 0; k < pad; k++) begin
				pool_tag[pool_fill] = '0;
				pool_word[pool_fill] = '0;
				pool_fill++;
			end
			slot = pool_fill;
			pool_fill += n;
		end
		for (k = 0; k < n; k++) begin
			pool_tag[slot + k] = q.tag[k];
			pool_word[slot + k] = q.word[k];
		end
		addr = 12'(slot + lane_base);
		res.row = addr[10:2];
		res.lane = addr[1:0];
		res.whole = (n == COMP_N);
		res.reused = hit;
		return res;
	endfunction

	function automatic int unsigned draw_wait();
		if ($urandom_range(0, 15) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic const_req_t next_req();
		const_req_t  q;
		int unsigned pick, start, k, idx;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0)
			q.count = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(5, 7));
		else
			q.count = 3'($urandom_range(1, 4));
		for (k = 0; k < COMP_N; k++) begin
			q.tag[k] = 4'($urandom_range(0, 15));
			q.word[k] = $urandom;
		end
		if (pick < 60 && pool_fill != 0) begin
			start = $urandom_range(0, pool_fill - 1);
			for (k = 0; k < COMP_N; k++)
				if (start + k < pool_fill && pool_tag[start + k] != 0) begin
					q.tag[k] = pool_tag[start + k];
					q.word[k] = pool_word[start + k];
				end
		end else if (pick < 85) begin
			for (k = 0; k < COMP_N; k++) begin
				idx = $urandom_range(0, 15);
				q.tag[k] = pair_tag[idx];
				q.word[k] = pair_word[idx];
			end
		end
		return q;
	endfunction

	task automatic push_req(input const_req_t q);
		pending.push_back(q);
		queued_n++;
	endtask

	task automatic queue_direct(input logic [CNT_IN_W-1:0] n, input logic [15:0] tags,
	                            input logic [127:0] words);
		const_req_t q;
		int         k;
		q.count = n;
		for (k = 0; k < COMP_N; k++) begin
			q.tag[k] = tags[4*k +: 4];
			q.word[k] = words[32*k +: 32];
		end
		push_req(q);
	endtask

	task automatic write_offset(input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		lane_base = v;
	endtask

	task automatic drain();
		while (sent_n != queued_n || allocs_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic report(input string what, input int unsigned got, input int unsigned want);
		$display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
		mismatches++;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_n++;
		if (cycle_n == LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// input side: hold while stalled, advance after each transfer
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !req_taken)) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (pending.size() != 0) begin
				cur_req = pending.pop_front();
				comp_count <= cur_req.count;
				tag_a <= cur_req.tag[0];
				word_a <= cur_req.word[0];
				tag_b <= cur_req.tag[1];
				word_b <= cur_req.word[1];
				tag_c <= cur_req.tag[2];
				word_c <= cur_req.word[2];
				tag_d <= cur_req.tag[3];
				word_d <= cur_req.word[3];
				in_valid <= 1'b1;
				gap_left = draw_wait();
			end else
				in_valid <= 1'b0;
		end
	end

	// result side: stall each result for a randomly drawn wait
	always @(negedge clk) begin
		if (res_taken)
			stall_left = draw_wait();
		if (out_valid && out_stall && stall_left != 0)
			stall_left--;
		out_stall <= (stall_left != 0);
	end

	always @(posedge clk) begin
		req_taken <= arst_n && in_valid && !in_stall;
		res_taken <= arst_n && out_valid && !out_stall;
		if (arst_n && in_valid && !in_stall) begin
			allocs_due.push_back(allocate(cur_req));
			sent_n++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (allocs_due.size() == 0)
				report("result with no request", row_index, 0);
			else begin
				head = allocs_due.pop_front();
				if (row_index !== head.row)
					report("row_index", row_index, head.row);
				if (lane_select !== head.lane)
					report("lane_select", lane_select, head.lane);
				if (whole_vector !== head.whole)
					report("whole_vector", whole_vector, head.whole);
				if (was_reused !== head.reused)
					report("was_reused", was_reused, head.reused);
				if (overflow !== head.ovf)
					report("overflow", overflow, head.ovf);
			end
		end
	end

	initial begin
		logic [CFG_W-1:0] offs [6];
		int               ph, i;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		comp_count = '0;
		{tag_a, tag_b, tag_c, tag_d} = '0;
		{word_a, word_b, word_c, word_d} = '0;
		pool_fill = 0;
		lane_base = '0;
		foreach (pair_tag[j]) begin
			pair_tag[j] = 4'($urandom_range(0, 15));
			pair_word[j] = $urandom;
		end
		offs = '{10'd1023, 10'($urandom), 10'd1, 10'($urandom), 10'd1023, 10'd0};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_offset(10'd0);
		queue_direct(3'd1, 16'h0001, 128'h0);
		queue_direct(3'd4, 16'hFFFF, {4{32'hFFFF_FFFF}});
		queue_direct(3'd4, 16'hFFFF, {4{32'hFFFF_FFFF}});
		queue_direct(3'd1, 16'h0001, 128'h0);
		queue_direct(3'd2, 16'h0000, {64'h0, 32'h1234, 32'h5678});
		queue_direct(3'd2, 16'h0043, {64'h0, 32'h6, 32'h5});
		queue_direct(3'd0, 16'h0001, 128'h0);
		queue_direct(3'd7, 16'hFFFF, {4{32'hFFFF_FFFF}});
		queue_direct(3'd5, 16'h8421, {32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h1, 32'h8000_0000});
		queue_direct(3'd3, 16'h0222, {32'h0, 32'h3, 32'h2, 32'h1});
		queue_direct(3'd2, 16'h00EE, {64'h0, 32'h22, 32'h11});
		queue_direct(3'd3, 16'h0876, {32'h0, 32'd80, 32'd70, 32'd60});
		queue_direct(3'd2, 16'h0098, {64'h0, 32'd90, 32'd80});
		queue_direct(3'd6, 16'h0000, 128'h0);
		queue_direct(3'd1, 16'h000F, {96'h0, 32'hFFFF_FFFF});
		queue_direct(3'd1, 16'h000A, {96'h0, 32'hDEAD_BEEF});
		queue_direct(3'd4, 16'h0F0F, {32'h0, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFE});
		queue_direct(3'd3, 16'h0010, {32'h0, 32'h0, 32'h0, 32'h0});
		drain();

		for (ph = 0; ph < 6; ph++) begin
			write_offset(offs[ph]);
			for (i = 0; i < 80; i++) begin
				while (pending.size() != 0)
					@(posedge clk);
				push_req(next_req());
			end
			drain();
		end

		repeat (CAP + 16) @(posedge clk);
		if (mismatches == 0 && allocs_due.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule
